>>> src/lrrs_pkg.sv
// ----------------------------------------------------------------------------
// lrrs_pkg
// Types, constants and the cell rule shared by the Life row stream block.
// ----------------------------------------------------------------------------
`default_nettype none

package lrrs_pkg;

   localparam int unsigned ROW_W = 32;

   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

   typedef logic [ROW_W-1:0] row_type;

   typedef struct packed {
      row_type next_cells;
      logic    last_of_grid;
   } rsp_type;

   typedef struct packed {
      logic upper;
      logic middle;
      logic row;
   } nbr_type;

   typedef struct packed {
      logic step;
      logic rows_seen;
      logic final_row;
   } ctl_type;

   typedef struct packed {
      logic first;
      logic second;
   } push_type;

   // bit 2 east, bit 1 own column, bit 0 west
   function automatic logic life_next(logic [2:0] above, logic [2:0] here,
                                      logic [2:0] below);
      logic [3:0] count;
      count = 4'(above[0]) + 4'(above[1]) + 4'(above[2])
            + 4'(below[0]) + 4'(below[1]) + 4'(below[2])
            + 4'(here[0])  + 4'(here[2]);
      return (count == BIRTH_COUNT) || ((count == SURVIVE_COUNT) && here[1]);
   endfunction

endpackage

`default_nettype wire

>>> src/lrrs_if.sv
// ----------------------------------------------------------------------------
// lrrs_if
// Valid/ready channels for row beats in and next-generation row beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrrs_req_if;
   logic                    valid;
   logic                    ready;
   logic [lrrs_pkg::ROW_W-1:0] row_cells;
   logic                    final_row;

   modport source (output valid, output row_cells, output final_row, input ready);
   modport sink   (input valid, input row_cells, input final_row, output ready);
endinterface

interface lrrs_rsp_if;
   logic                    valid;
   logic                    ready;
   logic [lrrs_pkg::ROW_W-1:0] next_cells;
   logic                    last_of_grid;

   modport source (output valid, output next_cells, output last_of_grid, input ready);
   modport sink   (input valid, input next_cells, input last_of_grid, output ready);
endinterface

`default_nettype wire

>>> src/lrrs_cell.sv
// ----------------------------------------------------------------------------
// lrrs_cell
// One grid column: holds its bits of the two previous rows and works out
// both possible next-generation bits from its own and its neighbours' bits.
// ----------------------------------------------------------------------------
`default_nettype none

module lrrs_cell import lrrs_pkg::*; (
   input  wire     clock,
   input  wire     reset,
   input  ctl_type ctl,
   input  wire     row_bit,
   input  nbr_type west,
   input  nbr_type east,
   output nbr_type own,
   output logic    first_bit,
   output logic    second_bit
);

   logic upper_ff,  upper_in;
   logic middle_ff, middle_in;
   logic [2:0] above0, here0, below0;
   logic [2:0] mid_trio, row_trio;

   always_comb begin
      mid_trio = {east.middle, middle_ff, west.middle};
      row_trio = {east.row, row_bit, west.row};
      if (ctl.rows_seen) begin
         above0 = {east.upper, upper_ff, west.upper};
         here0  = mid_trio;
         below0 = row_trio;
      end else begin
         above0 = '0;
         here0  = row_trio;
         below0 = '0;
      end
      first_bit  = life_next(above0, here0, below0);
      second_bit = life_next(mid_trio, row_trio, 3'b000);
   end

   always_comb begin
      upper_in  = upper_ff;
      middle_in = middle_ff;
      if (ctl.step) begin
         if (ctl.final_row) begin
            upper_in  = 1'b0;
            middle_in = 1'b0;
         end else begin
            upper_in  = ctl.rows_seen & middle_ff;
            middle_in = row_bit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff  <= 1'b0;
         middle_ff <= 1'b0;
      end else begin
         upper_ff  <= upper_in;
         middle_ff <= middle_in;
      end
   end

   assign own = '{upper: upper_ff, middle: middle_ff, row: row_bit};

endmodule

`default_nettype wire

>>> src/lrrs_out_queue.sv
// ----------------------------------------------------------------------------
// lrrs_out_queue
// Three-entry result queue: takes up to two beats a cycle, drives one out.
// ----------------------------------------------------------------------------
`default_nettype none

module lrrs_out_queue import lrrs_pkg::*; (
   input  wire     clock,
   input  wire     reset,
   input  push_type push,
   input  rsp_type first_rsp,
   input  rsp_type second_rsp,
   output logic    can_take,
   lrrs_rsp_if.source rsp_if
);

   localparam int unsigned DEPTH = 3;

   rsp_type    q_ff [DEPTH];
   rsp_type    q_in [DEPTH];
   rsp_type    shifted [DEPTH];
   logic [1:0] count_ff, count_in;
   logic [1:0] base;
   logic       pop;

   always_comb begin
      pop = (count_ff != 2'd0) && rsp_if.ready;
      base = count_ff - 2'(pop);
      for (int i = 0; i < DEPTH - 1; i++) begin
         shifted[i] = pop ? q_ff[i+1] : q_ff[i];
      end
      shifted[DEPTH-1] = q_ff[DEPTH-1];
      for (int i = 0; i < DEPTH; i++) begin
         if (push.first && (2'(i) == base)) begin
            q_in[i] = first_rsp;
         end else if (push.second && (2'(i) == base + 2'd1)) begin
            q_in[i] = second_rsp;
         end else begin
            q_in[i] = shifted[i];
         end
      end
      count_in = base + 2'(push.first) + 2'(push.second);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

   assign can_take            = (count_ff <= 2'd1);
   assign rsp_if.valid        = (count_ff != 2'd0);
   assign rsp_if.next_cells   = q_ff[0].next_cells;
   assign rsp_if.last_of_grid = q_ff[0].last_of_grid;

endmodule

`default_nettype wire

>>> src/life_rule_row_stream.sv
// ----------------------------------------------------------------------------
// life_rule_row_stream
// One generation of Life (birth on 3, survival on 2 or 3) on a row stream.
//
// Rows of the current generation arrive on req_if as beats, top row first,
// with final_row set on the bottom row. Bit k of a row is column k; columns
// at or above GRID_WIDTH are dead. Each row beat after the first yields the
// next-generation value of the row above it on rsp_if; the bottom row beat
// yields two beats, the row above and then itself with last_of_grid set. A
// grid of one row yields one beat.
// A row of column cells, one per column below GRID_WIDTH and ROW_W, holds
// the two previous rows, so every row is evaluated in the cycle it is
// accepted; results are registered in the output queue. One row beat per
// cycle is taken while results drain; the bottom row's two beats leave the
// three-beat queue one at a time. The queue lets req_if keep flowing while
// rsp_if stalls; req_if.ready drops once two beats wait. Reset empties the
// queue and clears the row window; ready is high after a reset edge.
// ----------------------------------------------------------------------------
`default_nettype none

module life_rule_row_stream import lrrs_pkg::*; #(
   parameter int unsigned GRID_WIDTH = 32
) (
   input  wire        clock,
   input  wire        reset,
   lrrs_req_if.sink   req_if,
   lrrs_rsp_if.source rsp_if
);

   localparam int unsigned NCOL = (GRID_WIDTH < ROW_W) ? GRID_WIDTH : ROW_W;

   logic     rows_seen_ff, rows_seen_in;
   ctl_type  ctl;
   push_type push;
   rsp_type  first_rsp, second_rsp;
   row_type  first_row, second_row;
   nbr_type  col_state [NCOL];
   logic     can_take;

   assign ctl = '{step:      req_if.valid && req_if.ready,
                  rows_seen: rows_seen_ff,
                  final_row: req_if.final_row};

   for (genvar i = 0; i < ROW_W; i++) begin : g_col
      if (i < NCOL) begin : g_cell
         nbr_type west, east;
         if (i == 0) begin : g_west_edge
            assign west = '0;
         end else begin : g_west
            assign west = col_state[i-1];
         end
         if (i == NCOL - 1) begin : g_east_edge
            assign east = '0;
         end else begin : g_east
            assign east = col_state[i+1];
         end
         lrrs_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .row_bit    (req_if.row_cells[i]),
            .west       (west),
            .east       (east),
            .own        (col_state[i]),
            .first_bit  (first_row[i]),
            .second_bit (second_row[i])
         );
      end else begin : g_dead
         assign first_row[i]  = 1'b0;
         assign second_row[i] = 1'b0;
      end
   end

   always_comb begin
      rows_seen_in = rows_seen_ff;
      if (ctl.step) begin
         rows_seen_in = !req_if.final_row;
      end
      push.first  = ctl.step && (rows_seen_ff || req_if.final_row);
      push.second = ctl.step && rows_seen_ff && req_if.final_row;
      first_rsp   = '{next_cells: first_row,
                      last_of_grid: req_if.final_row && !rows_seen_ff};
      second_rsp  = '{next_cells: second_row, last_of_grid: 1'b1};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_seen_ff <= 1'b0;
      end else begin
         rows_seen_ff <= rows_seen_in;
      end
   end

   lrrs_out_queue u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .first_rsp  (first_rsp),
      .second_rsp (second_rsp),
      .can_take   (can_take),
      .rsp_if     (rsp_if)
   );

   assign req_if.ready = can_take;

endmodule

`default_nettype wire

>>> src/lrrs_checker.sv
// ----------------------------------------------------------------------------
// lrrs_checker
// Port-level checks of the Life row stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lrrs_checker import lrrs_pkg::*; (
   input wire             clock,
   input wire             reset,
   input wire             req_valid,
   input wire             req_ready,
   input wire             req_final_row,
   input wire             rsp_valid,
   input wire             rsp_ready,
   input wire [ROW_W-1:0] rsp_next_cells,
   input wire             rsp_last_of_grid
);

   logic req_beat;
   assign req_beat = req_valid && req_ready;

   a_ready_after_reset : assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("ready low after reset");

   a_empty_after_reset : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat straight after reset");

   a_first_row_silent : assert property (@(posedge clock) disable iff (reset)
      ($past(reset) && req_beat && !req_final_row) |=> !rsp_valid)
      else $error("first row of a grid produced a beat");

   a_bottom_row_yields : assert property (@(posedge clock) disable iff (reset)
      (req_beat && req_final_row) |=> rsp_valid)
      else $error("bottom row produced no beat");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_next_cells) && $stable(rsp_last_of_grid)))
      else $error("stalled result beat changed");

endmodule

bind life_rule_row_stream lrrs_checker u_lrrs_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .req_final_row    (req_if.final_row),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_next_cells   (rsp_if.next_cells),
   .rsp_last_of_grid (rsp_if.last_of_grid)
);

`default_nettype wire

>>> tb/lrrs_next_gen_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lrrs_next_gen_check
// Watches both row channels, works out the next generation and compares.
//
// Every row beat accepted on the request channel goes through a row window of
// its own. The window gives the next-generation rows that the beat completes,
// with a dead border around the grid. Those rows are queued in order. Every
// beat accepted on the result channel is compared field by field with the
// oldest queued row. A beat with nothing queued counts as a failure, and so
// does a wrong field. The failure count and the number of rows still owed go
// back to the test top.
// ----------------------------------------------------------------------------
`default_nettype none

module lrrs_next_gen_check import lrrs_pkg::*; #(
   parameter int unsigned GRID_W = 32
) (
   input  wire  clock,
   input  wire  reset,
   lrrs_req_if  req_if,
   lrrs_rsp_if  rsp_if,
   output int   errors,
   output int   pending
);

   row_type above_q;
   row_type centre_q;
   logic    holding_q;
   rsp_type rows_due[$];

   function automatic row_type next_gen(row_type above, row_type here, row_type below);
      row_type result;
      int      live;
      int      c;
      result = '0;
      for (int col = 0; col < int'(GRID_W); col++) begin
         live = 0;
         for (int d = -1; d <= 1; d++) begin
            c = col + d;
            if (c >= 0 && c < int'(GRID_W)) begin
               live += int'(above[c]) + int'(below[c]);
               if (d != 0)
                  live += int'(here[c]);
            end
         end
         result[col] = (live == 3) || (live == 2 && here[col]);
      end
      return result;
   endfunction

   task automatic expect_row(row_type cells, logic last);
      rsp_type due;
      due.next_cells   = cells;
      due.last_of_grid = last;
      rows_due.push_back(due);
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type got;
      row_type cells;
      if (reset) begin
         above_q   = '0;
         centre_q  = '0;
         holding_q = 1'b0;
         rows_due.delete();
         errors    = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.next_cells   = rsp_if.next_cells;
            got.last_of_grid = rsp_if.last_of_grid;
            if (rows_due.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: unexpected beat next_cells %h last_of_grid %b",
                           $time, got.next_cells, got.last_of_grid);
            end else begin
               want = rows_due.pop_front();
               if (got.next_cells !== want.next_cells ||
                   got.last_of_grid !== want.last_of_grid) begin
                  errors++;
                  if (errors <= 10)
                     $display("%0t: next_cells %h last_of_grid %b, expected %h %b",
                              $time, got.next_cells, got.last_of_grid,
                              want.next_cells, want.last_of_grid);
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            cells = req_if.row_cells;
            if (!holding_q) begin
               if (req_if.final_row) begin
                  expect_row(next_gen('0, cells, '0), 1'b1);
               end else begin
                  above_q   = '0;
                  centre_q  = cells;
                  holding_q = 1'b1;
               end
            end else begin
               expect_row(next_gen(above_q, centre_q, cells), 1'b0);
               if (req_if.final_row) begin
                  expect_row(next_gen(centre_q, cells, '0), 1'b1);
                  above_q   = '0;
                  centre_q  = '0;
                  holding_q = 1'b0;
               end else begin
                  above_q  = centre_q;
                  centre_q = cells;
               end
            end
         end
      end
      pending = rows_due.size();
   end

endmodule

`default_nettype wire

>>> tb/life_rule_row_stream_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// life_rule_row_stream_test
// Drives grids of rows through the Life row stream block and gives a verdict.
//
// A short directed part comes first: single-row grids, grids of all-live and
// all-dead rows, blinkers at the middle and at both edge columns, a
// checkerboard and a glider. Random grids of mixed height and cell density
// follow in three phases of handshake pressure: first a quick sender with a
// busy receiver, then the other way round, then full rate. A separate check
// module predicts and compares. A watchdog ends the run if nothing moves.
// ----------------------------------------------------------------------------
`default_nettype none

module life_rule_row_stream_test import lrrs_pkg::*;;

   localparam int unsigned GRID_W      = 32;
   localparam int unsigned PHASE_ROWS  = 390;
   localparam int unsigned STALL_LIMIT = 2000;

   logic        clock = 1'b0;
   logic        reset;
   int unsigned tx_idle_pct;
   int unsigned rx_stall_pct;
   int unsigned rows_sent;
   int unsigned quiet_cycles;
   int          errors;
   int          pending;

   lrrs_req_if req_if ();
   lrrs_rsp_if rsp_if ();

   always #5 clock = ~clock;

   life_rule_row_stream #(.GRID_WIDTH(GRID_W)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   lrrs_next_gen_check #(.GRID_W(GRID_W)) u_next_gen_check (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .rsp_if  (rsp_if),
      .errors  (errors),
      .pending (pending)
   );

   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= rx_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("life_rule_row_stream: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic row_type random_row(int unsigned density);
      case (density)
         0: return $urandom & $urandom & $urandom;
         1: return $urandom & $urandom;
         2: return $urandom;
         default: return $urandom | $urandom;
      endcase
   endfunction

   // hold the beat until it is taken
   task automatic send_row(row_type cells, logic last);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.row_cells <= cells;
      req_if.final_row <= last;
      do @(posedge clock); while (!req_if.ready);
      rows_sent++;
   endtask

   task automatic run_phase(int unsigned tx_pct, int unsigned rx_pct, int unsigned rows);
      int unsigned target;
      int unsigned pick;
      int unsigned height;
      int unsigned density;
      tx_idle_pct  = tx_pct;
      rx_stall_pct = rx_pct;
      target       = rows_sent + rows;
      while (rows_sent < target) begin
         pick    = $urandom_range(19);
         density = $urandom_range(3);
         if (pick == 0)
            height = $urandom_range(40, 24);
         else if (pick < 4)
            height = $urandom_range(2, 1);
         else
            height = $urandom_range(12, 3);
         for (int unsigned r = 0; r < height; r++)
            send_row(random_row(density), r == height - 1);
      end
   endtask

   initial begin
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.row_cells <= '0;
      req_if.final_row <= 1'b0;
      tx_idle_pct  = 20;
      rx_stall_pct = 66;
      rows_sent    = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // single-row grids
      send_row('1, 1'b1);
      send_row('0, 1'b1);
      send_row(32'h8000_0001, 1'b1);
      // two live rows
      send_row('1, 1'b0);
      send_row('1, 1'b1);
      // blinkers: middle, then both edge columns
      send_row(32'h0000_0100, 1'b0);
      send_row(32'h0000_0100, 1'b0);
      send_row(32'h0000_0100, 1'b1);
      send_row(32'h8000_0001, 1'b0);
      send_row(32'h8000_0001, 1'b0);
      send_row(32'h8000_0001, 1'b1);
      send_row(32'hC000_0003, 1'b0);
      send_row(32'hC000_0003, 1'b1);
      // checkerboard
      send_row(32'hAAAA_AAAA, 1'b0);
      send_row(32'h5555_5555, 1'b0);
      send_row(32'hAAAA_AAAA, 1'b0);
      send_row(32'h5555_5555, 1'b1);
      // glider
      send_row(32'h0000_0002, 1'b0);
      send_row(32'h0000_0004, 1'b0);
      send_row(32'h0000_0007, 1'b0);
      send_row('0, 1'b1);

      run_phase(20, 66, PHASE_ROWS);
      run_phase(66, 20, PHASE_ROWS);
      run_phase(0, 0, PHASE_ROWS);
      req_if.valid <= 1'b0;

      do @(negedge clock); while (pending != 0);
      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("life_rule_row_stream: match");
      else
         $display("life_rule_row_stream: mismatch");
      $finish;
   end

endmodule

`default_nettype wire

>>> filelist.f
src/lrrs_pkg.sv
src/lrrs_if.sv
src/lrrs_cell.sv
src/lrrs_out_queue.sv
src/life_rule_row_stream.sv
src/lrrs_checker.sv
tb/lrrs_next_gen_check.sv
tb/life_rule_row_stream_test.sv
